>>> sv/spq_pkg.sv
// Package for the strict priority packet queues.
// Sizes, types and sequencer codes; no dependencies.
`default_nettype none
package spq_pkg;
    localparam int QUEUE_DEPTH    = 16;
    localparam int NUM_PRIORITIES = 8;
    localparam int MAX_SEND       = 32;
    localparam int RING_SIZE      = QUEUE_DEPTH + 1;
    localparam int STORE_DEPTH    = NUM_PRIORITIES * RING_SIZE;
    localparam int PRIO_W         = $clog2(NUM_PRIORITIES);
    localparam int RING_W         = $clog2(RING_SIZE + 1);
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int LIMIT_W        = 6;
    localparam int SENT_W         = $clog2(MAX_SEND + 1);

    localparam logic ACTION_RECEIVE = 1'b0;
    localparam logic ACTION_SEND    = 1'b1;

    typedef struct packed {
        logic                action;
        logic [2:0]          priority_req;
        logic [15:0]         packet_id;
        logic [LIMIT_W-1:0]  send_limit;
    } in_item_t;

    typedef struct packed {
        logic [15:0] packet_id_res;
        logic [2:0]  priority_res;
        logic        none_sent;
        logic        last;
    } out_item_t;

    // storage port request from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [15:0]       wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;

    // ring offset wraps once at most
    function automatic logic [RING_W-1:0] ring_add(input logic [RING_W-1:0] a,
                                                  input logic [RING_W-1:0] b);
        logic [RING_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (RING_W+1)'(RING_SIZE))
            s = s - (RING_W+1)'(RING_SIZE);
        return s[RING_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot(input logic [PRIO_W-1:0] q,
                                              input logic [RING_W-1:0] idx);
        return ADDR_W'(q) * ADDR_W'(RING_SIZE) + ADDR_W'(idx);
    endfunction
endpackage
`default_nettype wire

>>> sv/spq_if.sv
// Valid/ready channels carrying one transaction of type in_item_t or out_item_t.
// Depends on spq_pkg for payload types.
`default_nettype none
interface spq_in_if;
    logic                valid;
    logic                ready;
    spq_pkg::in_item_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spq_out_if;
    logic                valid;
    logic                ready;
    spq_pkg::out_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/spq_store.sv
// Handle storage: one write port, one registered read port.
// Depends on spq_pkg.
`default_nettype none
module spq_store (
    input  wire logic               clk,
    input  wire spq_pkg::store_req_t req,
    output logic [15:0]             rd_data
);
    import spq_pkg::*;
    logic [15:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
        rd_data <= mem[req.rd_addr];
    end
endmodule
`default_nettype wire

>>> sv/strict_priority_packet_queues.sv
// Strict priority packet queues, top level with sequencer.
// Depends on spq_pkg, spq_if and spq_store.
//
// Usage: items enter on in_ch (valid/ready); results leave on out_ch.
// A receive appends packet_id to the FIFO of priority_req and gives no
// result; when the FIFO exceeds its depth, every second entry is dropped
// by reading and rewriting the kept entries through the store. A send
// emits up to send_limit (saturated at 32) results, highest non-empty
// priority first, each going through search, store read and output; the
// final one has last set. With nothing to send a single none_sent result
// appears. The store has one read and one write port, so one transaction
// is in work at a time and in_ch.ready is low meanwhile.
// Reset clears queue counts and heads; storage contents are left as is.
// When out_ch.ready is low the pending result is held and the sequencer
// waits; no result is lost or repeated.
`default_nettype none
module strict_priority_packet_queues (
    input  wire logic clk,
    input  wire logic rst_n,
    spq_in_if.sink    in_ch,
    spq_out_if.source out_ch
);
    import spq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RECV = 3'd1;
    localparam logic [2:0] ST_DRD  = 3'd2;
    localparam logic [2:0] ST_DWR  = 3'd3;
    localparam logic [2:0] ST_SRCH = 3'd4;
    localparam logic [2:0] ST_SRD  = 3'd5;
    localparam logic [2:0] ST_SOUT = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [RING_W-1:0] count_reg [NUM_PRIORITIES];
    logic [RING_W-1:0] head_reg  [NUM_PRIORITIES];
    in_item_t          item_reg;
    logic [RING_W-1:0] k_reg, k_next, keep_reg;
    logic [SENT_W-1:0] sent_reg, limit_reg;
    logic [PRIO_W-1:0] q_reg;
    logic              ov_reg, ov_next;
    out_item_t         res_reg;
    logic [15:0]       rd_data;
    store_req_t        req;

    logic              any_full;
    logic [PRIO_W-1:0] top_q;
    logic [PRIO_W-1:0] pq;

    spq_store u_store (.clk(clk), .req(req), .rd_data(rd_data));

    assign pq = item_reg.priority_req[PRIO_W-1:0];

    always_comb
    begin
        any_full = 1'b0;
        top_q = '0;
        for (int i = 0; i < NUM_PRIORITIES; i++)
        begin
            if (count_reg[i] != '0)
            begin
                any_full = 1'b1;
                top_q = PRIO_W'(i);
            end
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = ov_reg;
    assign out_ch.data = res_reg;

    always_comb
    begin
        req.wr_en = 1'b0;
        req.wr_addr = slot(pq, ring_add(head_reg[pq], count_reg[pq]));
        req.wr_data = item_reg.packet_id;
        req.rd_addr = slot(pq, ring_add(head_reg[pq], RING_W'({k_reg, 1'b0})));
        k_next = k_reg;
        unique case (state_reg)
            ST_IDLE: k_next = '0;
            ST_RECV: req.wr_en = 1'b1;
            ST_DWR:
            begin
                req.wr_en = 1'b1;
                req.wr_addr = slot(pq, ring_add(head_reg[pq], k_reg));
                req.wr_data = rd_data;
                k_next = k_reg + 1'b1;
            end
            ST_SRD: req.rd_addr = slot(q_reg, head_reg[q_reg]);
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_ch.valid)
                    state_next = (in_ch.data.action == ACTION_SEND) ? ST_SRCH : ST_RECV;
            ST_RECV:
                state_next = (count_reg[pq] >= RING_W'(QUEUE_DEPTH)) ? ST_DRD : ST_IDLE;
            ST_DRD: state_next = ST_DWR;
            ST_DWR: state_next = (k_next == keep_reg) ? ST_IDLE : ST_DRD;
            ST_SRCH:
                if (!ov_reg || out_ch.ready)
                begin
                    if (sent_reg < limit_reg && any_full)
                        state_next = ST_SRD;
                    else
                        state_next = ST_IDLE;
                end
            ST_SRD: state_next = ST_SOUT;
            ST_SOUT: state_next = ST_SRCH;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg && !out_ch.ready;
        if (state_reg == ST_SOUT)
            ov_next = 1'b1;
        else if (state_reg == ST_SRCH && (!ov_reg || out_ch.ready) &&
                 !(sent_reg < limit_reg && any_full) && sent_reg == '0)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            for (int i = 0; i < NUM_PRIORITIES; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i] <= '0;
            end
            k_reg <= '0;
            sent_reg <= '0;
            keep_reg <= '0;
            q_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            ov_reg <= ov_next;
            unique case (state_reg)
                ST_IDLE:
                    if (in_ch.valid)
                        sent_reg <= '0;
                ST_RECV:
                    if (count_reg[pq] >= RING_W'(QUEUE_DEPTH))
                        keep_reg <= RING_W'((QUEUE_DEPTH + 2) / 2);
                    else
                        count_reg[pq] <= count_reg[pq] + 1'b1;
                ST_DWR:
                    if (k_next == keep_reg)
                        count_reg[pq] <= keep_reg;
                ST_SRCH:
                    if (!ov_reg || out_ch.ready)
                    begin
                        if (sent_reg < limit_reg && any_full)
                            q_reg <= top_q;
                        else if (sent_reg == '0)
                            res_reg <= '{packet_id_res: '0, priority_res: '0,
                                         none_sent: 1'b1, last: 1'b1};
                    end
                ST_SRD:
                begin
                    head_reg[q_reg] <= ring_add(head_reg[q_reg], RING_W'(1));
                    count_reg[q_reg] <= count_reg[q_reg] - 1'b1;
                    sent_reg <= sent_reg + 1'b1;
                end
                ST_SOUT:
                begin
                    res_reg.packet_id_res <= rd_data;
                    res_reg.priority_res <= 3'(q_reg);
                    res_reg.none_sent <= 1'b0;
                    res_reg.last <= (sent_reg >= limit_reg) || !any_full;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
        begin
            item_reg <= in_ch.data;
            limit_reg <= (in_ch.data.send_limit > LIMIT_W'(MAX_SEND)) ?
                         SENT_W'(MAX_SEND) : SENT_W'(in_ch.data.send_limit);
        end
    end

    a_ov_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ch.ready |=> ov_reg && $stable(res_reg))
        else $error("result dropped under stall");
    a_sout_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SOUT |-> !ov_reg)
        else $error("result overwritten");
    a_sent_lim: assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg <= limit_reg || state_reg == ST_IDLE)
        else $error("send count beyond limit");
    a_srd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SRD |-> count_reg[q_reg] != '0)
        else $error("pop from empty queue");
endmodule
`default_nettype wire

>>> bench/strict_priority_packet_queues_test.sv
// Testbench for strict_priority_packet_queues: random and directed receive/send traffic,
// results checked against a behavioral model of the priority FIFOs.
// Depends on spq_pkg, spq_if and the block RTL.
`default_nettype none
module strict_priority_packet_queues_test;
    import spq_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    strict_priority_packet_queues dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    logic [15:0] fifo_handles [NUM_PRIORITIES][$];
    out_item_t   pending_results [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          long_gaps = 1'b1;

    task automatic predict(input in_item_t t);
        int limit;
        int sent;
        int q;
        int found;
        int k;
        out_item_t r;
        logic [15:0] kept [$];
        if (t.action == ACTION_RECEIVE)
        begin
            if (int'(t.priority_req) >= NUM_PRIORITIES)
                return;
            fifo_handles[t.priority_req].push_back(t.packet_id);
            if (fifo_handles[t.priority_req].size() > QUEUE_DEPTH)
            begin
                kept = {};
                for (k = 0; k < fifo_handles[t.priority_req].size(); k++)
                    if (k % 2 == 0)
                        kept.push_back(fifo_handles[t.priority_req][k]);
                fifo_handles[t.priority_req] = kept;
            end
            return;
        end
        limit = (t.send_limit > MAX_SEND) ? MAX_SEND : int'(t.send_limit);
        sent = 0;
        while (sent < limit)
        begin
            found = -1;
            for (q = NUM_PRIORITIES - 1; q >= 0; q--)
                if (found < 0 && fifo_handles[q].size() != 0)
                    found = q;
            if (found < 0)
                break;
            r.packet_id_res = fifo_handles[found].pop_front();
            r.priority_res  = 3'(found);
            r.none_sent     = 1'b0;
            r.last          = 1'b0;
            pending_results.push_back(r);
            sent++;
        end
        if (sent == 0)
        begin
            r = '0;
            r.none_sent = 1'b1;
            r.last = 1'b1;
            pending_results.push_back(r);
        end
        else
            pending_results[pending_results.size() - 1].last = 1'b1;
    endtask

    // at least one edge so valid is never dropped and raised in the same step
    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0 && long_gaps) ? $urandom_range(5, 30)
                                                      : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_transaction(input in_item_t t);
        random_gap();
        in_ch.valid <= 1'b1;
        in_ch.data  <= t;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict(t);
        in_ch.valid <= 1'b0;
    endtask

    function automatic in_item_t receive_item(input int prio, input int id);
        in_item_t t;
        t.action = ACTION_RECEIVE;
        t.priority_req = 3'(prio);
        t.packet_id = 16'(id);
        t.send_limit = 6'($urandom_range(0, 63));
        return t;
    endfunction

    function automatic in_item_t send_item(input int limit);
        in_item_t t;
        t.action = ACTION_SEND;
        t.priority_req = 3'($urandom_range(0, 7));
        t.packet_id = 16'($urandom);
        t.send_limit = 6'(limit);
        return t;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(0, 3) != 0) ||
                            ($urandom_range(0, 1) == 0 && !long_gaps);
    end

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction %p", out_ch.data);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_ch.data.packet_id_res !== exp_r.packet_id_res)
                begin
                    $error("packet_id_res expected %0d actual %0d",
                           exp_r.packet_id_res, out_ch.data.packet_id_res);
                    error_count++;
                end
                if (out_ch.data.priority_res !== exp_r.priority_res)
                begin
                    $error("priority_res expected %0d actual %0d",
                           exp_r.priority_res, out_ch.data.priority_res);
                    error_count++;
                end
                if (out_ch.data.none_sent !== exp_r.none_sent)
                begin
                    $error("none_sent expected %0d actual %0d",
                           exp_r.none_sent, out_ch.data.none_sent);
                    error_count++;
                end
                if (out_ch.data.last !== exp_r.last)
                begin
                    $error("last expected %0d actual %0d", exp_r.last, out_ch.data.last);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("strict_priority_packet_queues_test: errors");
            $finish;
        end
    end

    task automatic test_empty_and_zero_limit();
        send_transaction(send_item(0));
        send_transaction(send_item(5));
        send_transaction(receive_item(3, 16'hFFFF));
        send_transaction(send_item(0));
        send_transaction(send_item(63));
    endtask

    task automatic test_priority_order();
        send_transaction(receive_item(0, 16'h0000));
        send_transaction(receive_item(7, 16'hAAAA));
        send_transaction(receive_item(4, 16'h5555));
        send_transaction(receive_item(7, 16'h1234));
        send_transaction(send_item(2));
        send_transaction(send_item(32));
    endtask

    task automatic test_overflow_decimation();
        for (int i = 0; i < 17; i++)
            send_transaction(receive_item(5, 16'h100 + i));
        wait_drained();
        send_transaction(send_item(33));
    endtask

    task automatic test_random_traffic();
        in_item_t t;
        for (int i = 0; i < 250; i++)
        begin
            if (i == 125)
            begin
                long_gaps = 1'b0;
                wait_drained();
            end
            if (i == 200)
                long_gaps = 1'b1;
            if ($urandom_range(0, 3) != 0)
                t = receive_item($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                      : $urandom_range(5, 7),
                                 $urandom);
            else
                t = send_item($urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                                        : $urandom_range(1, 12));
            send_transaction(t);
        end
        send_transaction(send_item(63));
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_zero_limit();
        test_priority_order();
        test_overflow_decimation();
        test_random_traffic();
        wait_drained();
        repeat (120) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("strict_priority_packet_queues_test: clean");
        else
            $display("strict_priority_packet_queues_test: errors");
        $finish;
    end
endmodule
`default_nettype wire
